### rtl/core/wgm_pkg.sv
// ============================================================================
// wgm_pkg
// Shared constants, register indexes and step control type for the wildcard
// glob matcher.
// ============================================================================
package wgm_pkg;

  localparam int BYTE_W        = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int LEN_W         = 6;
  localparam int BYTES_PER_REG = CFG_DATA_W / BYTE_W;

  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_ANY  = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHARS0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHARS1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHARS2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHARS3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH = 3'd4;

  typedef struct packed {
    logic              fire;
    logic              term;
    logic [BYTE_W-1:0] ch;
  } wgm_step_t;

endpackage

### rtl/core/wgm_cfg.sv
// ============================================================================
// wgm_cfg
// Pattern and length registers; decodes the live span of the pattern and
// the star positions inside it.
// ============================================================================
module wgm_cfg
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx,
  input  logic [CFG_DATA_W-1:0]                 cfg_wdata,
  output logic [PATTERN_MAX-1:0][BYTE_W-1:0]    pat_chars,
  output logic [PATTERN_MAX-1:0]                live,
  output logic [PATTERN_MAX-1:0]                star
);

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_r;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_nxt;
  logic [LEN_W-1:0]                   len_r;
  logic [LEN_W-1:0]                   len_nxt;
  logic [PATTERN_MAX-1:0]             nz;

  always_comb begin
    pat_nxt = pat_r;
    len_nxt = len_r;
    for (int b = 0; b < PATTERN_MAX; b++) begin
      if (cfg_we && cfg_idx == CFG_IDX_CHARS0 + CFG_IDX_W'(b / BYTES_PER_REG)) begin
        pat_nxt[b] = cfg_wdata[(b % BYTES_PER_REG)*BYTE_W +: BYTE_W];
      end
    end
    if (cfg_we && cfg_idx == CFG_IDX_LENGTH) begin
      len_nxt = cfg_wdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
    end else begin
      pat_r <= pat_nxt;
      len_r <= len_nxt;
    end
  end

  // position is live if below the length and no zero byte is at or before it
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    assign nz[i]   = (pat_r[i] != CHAR_NUL);
    assign live[i] = (LEN_W'(i) < len_r) && (&nz[i:0]);
    assign star[i] = live[i] && (pat_r[i] == CHAR_STAR);
  end

  assign pat_chars = pat_r;

endmodule

### rtl/core/wgm_nfa.sv
// ============================================================================
// wgm_nfa
// Active position vector, star closure; one byte step per cycle on step.fire.
// ============================================================================
module wgm_nfa
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  wgm_step_t                          step,
  input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_chars,
  input  logic [PATTERN_MAX-1:0]             live,
  input  logic [PATTERN_MAX-1:0]             star,
  output logic                               matched
);

  localparam int W    = PATTERN_MAX + 1;
  localparam int LVLS = $clog2(W);

  logic [W-1:0]           state_r;
  logic [W-1:0]           state_nxt;
  logic                   fold_r;
  logic                   fold_nxt;
  logic [W-1:0]           keep;
  logic [W-1:0]           end_pos;
  logic [W-1:0]           closed;
  logic [W-1:0]           gen;
  logic [W-1:0]           prop;
  logic [W-1:0]           nv;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] adv;
  logic [PATTERN_MAX-1:0] stay;

  assign keep    = {live, 1'b1};
  assign end_pos = keep & ~(keep >> 1);

  // prefix closure across star positions
  always_comb begin
    gen  = state_r & keep;
    prop = {star, 1'b0};
    for (int s = 0; s < LVLS; s++) begin
      gen  = gen | (prop & (gen << (1 << s)));
      prop = prop & (prop << (1 << s));
    end
    closed = gen;
  end

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      hit[j] = (pat_chars[j] == step.ch) || (pat_chars[j] == CHAR_ANY);
    end
    adv  = closed[PATTERN_MAX-1:0] & live & ~star & hit;
    stay = closed[PATTERN_MAX-1:0] & star;
    nv   = {adv, 1'b0} | {1'b0, stay};
  end

  assign matched = |(closed & end_pos);

  // the first config write after a non-zero-byte step folds the closure into the
  // stored vector; later writes, and writes after a zero-byte step, leave it alone
  always_comb begin
    state_nxt = state_r;
    fold_nxt  = fold_r;
    if (step.fire) begin
      state_nxt = step.term ? W'(1) : nv;
      fold_nxt  = !step.term;
    end else if (cfg_we && fold_r) begin
      state_nxt = closed;
      fold_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W'(1);
      fold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fold_r  <= fold_nxt;
    end
  end

endmodule

### rtl/core/wildcard_glob_matcher.sv
// ============================================================================
// wildcard_glob_matcher
// Streams text bytes against a '*' / '?' wildcard pattern held in config
// registers; a zero byte closes the string and returns one match word.
// ============================================================================
//
//  channel  direction  handshake         payload
//  -------  ---------  ----------------  ---------------------------
//  in       input      in_valid/in_stall in_text_byte[7:0]
//  out      output     out_valid/out_stall out_matched
//  cfg      input      cfg_we            cfg_idx[2:0], cfg_wdata[63:0]
//
//  One text byte per cycle while in_stall is low; a byte is held in the input
//  register, the NFA step runs behind it and a zero byte lands its result
//  in the output register in the cycle after its step fires.
//  in_stall rises only when a zero byte waits behind an unaccepted result.
//  Reset is synchronous; it clears the pattern and restarts at position zero.
//
module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_text_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_matched,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_chars;
  logic [PATTERN_MAX-1:0]             live;
  logic [PATTERN_MAX-1:0]             star;
  logic                               s1_valid_r;
  logic                               s1_valid_nxt;
  logic [BYTE_W-1:0]                  s1_char_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic                               out_matched_r;
  logic                               blocked;
  logic                               in_take;
  logic                               matched;
  wgm_step_t                          step;

  assign step.term = (s1_char_r == CHAR_NUL);
  assign step.ch   = s1_char_r;
  assign blocked   = s1_valid_r && step.term && out_valid_r && out_stall;
  assign step.fire = s1_valid_r && !blocked;
  assign in_stall  = blocked;
  assign in_take   = in_valid && !blocked;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (step.fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_valid_r && out_stall;
    if (step.fire && step.term) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_text_byte;
    end
    if (step.fire && step.term) begin
      out_matched_r <= matched;
    end
  end

  wgm_cfg #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pat_chars (pat_chars),
    .live      (live),
    .star      (star)
  );

  wgm_nfa #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_nfa (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .step      (step),
    .pat_chars (pat_chars),
    .live      (live),
    .star      (star),
    .matched   (matched)
  );

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

### tb/tb_wildcard_glob_matcher.sv
// ============================================================================
// tb_wildcard_glob_matcher
// Streams text words through the glob matcher and checks every match word
// against a bit-vector NFA kept in the testbench. Covers the reset pattern,
// directed corner patterns, pattern updates inside a string, random patterns
// and text under input gaps and output stalls, and a long output hold-off.
// ============================================================================
`timescale 1ns / 100ps

module tb_wildcard_glob_matcher;
  import wgm_pkg::*;

  localparam int PAT_MAX     = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic [BYTE_W-1:0]     in_text_byte = '0;
  logic                  out_stall    = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_matched;

  logic [CFG_DATA_W-1:0] pat_regs [4] = '{default: '0};
  logic [LEN_W-1:0]      pat_len      = '0;
  logic [PAT_MAX:0]      nfa_state    = 33'd1;
  bit                    expected_match [$];
  logic [BYTE_W-1:0]     text_buf [$];

  int errors       = 0;
  int n_words      = 0;
  int n_results    = 0;
  int n_settings   = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  wildcard_glob_matcher #(
    .PATTERN_MAX(PAT_MAX)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_text_byte(in_text_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_matched (out_matched),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] pat_char(int i);
    return pat_regs[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic int active_len();
    int n;
    n = int'(pat_len);
    if (n > PAT_MAX) n = PAT_MAX;
    for (int i = 0; i < n; i++) begin
      if (pat_char(i) == CHAR_NUL) return i;
    end
    return n;
  endfunction

  function automatic logic [63:0] star_closure(logic [63:0] v, int len);
    v = v & ((64'd1 << (len + 1)) - 64'd1);
    for (int i = 0; i < len; i++) begin
      if (v[i] && pat_char(i) == CHAR_STAR) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic void advance_nfa(logic [BYTE_W-1:0] c);
    int          len;
    logic [63:0] v;
    logic [63:0] nv;
    len = active_len();
    v   = star_closure({31'd0, nfa_state}, len);
    nv  = '0;
    if (c == CHAR_NUL) begin
      expected_match.push_back(v[len]);
      nfa_state = 33'd1;
    end else begin
      for (int i = 0; i < len; i++) begin
        if (v[i]) begin
          if (pat_char(i) == CHAR_STAR) nv[i] = 1'b1;
          else if (pat_char(i) == c || pat_char(i) == CHAR_ANY) nv[i+1] = 1'b1;
        end
      end
      nv = star_closure(nv, len);
      nfa_state = nv[PAT_MAX:0];
    end
  endfunction

  function automatic logic [255:0] str_chars(string s);
    logic [255:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 32; i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 75) return ($urandom_range(0, 1) != 0) ? CHAR_STAR : CHAR_ANY;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // predict on accepted input words, check accepted match words
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_IDX_CHARS0: pat_regs[0] = cfg_wdata;
          CFG_IDX_CHARS1: pat_regs[1] = cfg_wdata;
          CFG_IDX_CHARS2: pat_regs[2] = cfg_wdata;
          CFG_IDX_CHARS3: pat_regs[3] = cfg_wdata;
          CFG_IDX_LENGTH: pat_len = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_nfa(in_text_byte);
        n_words++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_match.size() == 0) begin
          report_mismatch($sformatf("match word %0b with none expected", out_matched));
        end else begin
          if (out_matched !== expected_match[0])
            report_mismatch($sformatf("matched %0b, expected %0b", out_matched,
                                      expected_match[0]));
          void'(expected_match.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
    send_word(CHAR_NUL);
  endtask

  task automatic send_bytes();
    foreach (text_buf[i]) send_word(text_buf[i]);
    send_word(CHAR_NUL);
  endtask

  // drop valid, drain results, then let the pipeline settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_match.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pattern(input logic [255:0] chars, input logic [63:0] len_word,
                             input bit junk);
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_CHARS0 + 3'(k);
      cfg_wdata <= chars[k*64 +: 64];
      @(posedge clk);
    end
    cfg_idx   <= CFG_IDX_LENGTH;
    cfg_wdata <= len_word;
    @(posedge clk);
    if (junk) begin
      for (int k = 1; k < 4; k++) begin
        cfg_idx   <= CFG_IDX_LENGTH + 3'(k);
        cfg_wdata <= {$urandom, $urandom};
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic rand_pattern(output logic [255:0] chars, output logic [63:0] len_word);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 60) n = $urandom_range(0, 8);
    else if (r < 88) n = $urandom_range(9, 32);
    else n = $urandom_range(33, 63);
    for (int i = 0; i < 32; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) chars[i*8 +: 8] = CHAR_STAR;
      else if (r < 35) chars[i*8 +: 8] = CHAR_ANY;
      else if (r < 85) chars[i*8 +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      else if (r < 88) chars[i*8 +: 8] = CHAR_NUL;
      else chars[i*8 +: 8] = 8'($urandom_range(0, 255));
    end
    len_word = {32'($urandom), 26'($urandom), 6'(n)};
  endtask

  // mostly strings built from the pattern, some mutated, some pure noise
  task automatic make_text();
    int                len;
    int                r;
    int                k;
    logic [BYTE_W-1:0] c;
    text_buf.delete();
    len = active_len();
    r   = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(0, 8)) text_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      for (int i = 0; i < len; i++) begin
        c = pat_char(i);
        if (c == CHAR_STAR) begin
          repeat ($urandom_range(0, 3)) text_buf.push_back(rand_text_char());
        end else if (c == CHAR_ANY) begin
          text_buf.push_back(rand_text_char());
        end else begin
          text_buf.push_back(c);
        end
      end
      if (r < 45) begin
        k = $urandom_range(0, 2);
        if (k == 0 || text_buf.size() == 0) text_buf.push_back(rand_text_char());
        else if (k == 1) text_buf.delete($urandom_range(0, text_buf.size() - 1));
        else text_buf[$urandom_range(0, text_buf.size() - 1)] = rand_text_char();
      end
    end
  endtask

  task automatic test_reset_defaults();
    quiesce();
    send_text("");
    send_text("x");
  endtask

  task automatic test_directed_patterns();
    logic [255:0] chars;
    quiesce();
    set_pattern(str_chars("a*b?"), {32'($urandom), 26'($urandom), 6'd4}, 1'b0);
    send_text("azbq");
    send_text("ab");
    quiesce();
    set_pattern({32{CHAR_STAR}}, 64'd63, 1'b0);
    send_word(8'hFF);
    send_word(8'h01);
    send_word(CHAR_NUL);
    quiesce();
    set_pattern(str_chars("?"), 64'd1, 1'b0);
    send_word(8'hFF);
    send_word(CHAR_NUL);
    chars = str_chars("ab_c");
    chars[23:16] = CHAR_NUL;
    quiesce();
    set_pattern(chars, 64'd4, 1'b0);
    send_text("ab");
    quiesce();
    set_pattern(str_chars("*"), 64'd1, 1'b0);
    send_text("*?");
    quiesce();
    set_pattern(str_chars("x?*"), 64'd0, 1'b1);
    send_text("");
  endtask

  task automatic test_mid_string_update();
    quiesce();
    set_pattern(str_chars("abc*"), 64'd4, 1'b0);
    send_word("a");
    send_word("b");
    quiesce();
    set_pattern(str_chars("abc*"), 64'd2, 1'b0);
    send_word(CHAR_NUL);
    send_word("a");
    send_word("b");
    quiesce();
    set_pattern(str_chars("x?*q"), 64'd4, 1'b0);
    send_word("q");
    send_word(CHAR_NUL);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int hold_pct, input int budget);
    int           sent;
    int           strings;
    logic [255:0] chars;
    logic [63:0]  len_word;
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    sent      = 0;
    strings   = 0;
    while (sent < budget) begin
      if (strings % 6 == 0) begin
        quiesce();
        rand_pattern(chars, len_word);
        set_pattern(chars, len_word, $urandom_range(0, 4) == 0);
      end
      make_text();
      send_bytes();
      sent += text_buf.size() + 1;
      strings++;
    end
    quiesce();
  endtask

  task automatic test_output_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    quiesce();
    set_pattern(str_chars("a*?"), 64'd3, 1'b0);
    hold_req++;
    repeat (40) begin
      make_text();
      send_bytes();
    end
    quiesce();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_patterns();
    test_mid_string_update();
    test_random_traffic(0, 0, 220);
    test_random_traffic(75, 0, 220);
    test_random_traffic(0, 75, 220);
    test_random_traffic(38, 38, 220);
    test_output_backpressure();
    quiesce();
    repeat (8) @(posedge clk);
    if (expected_match.size() != 0)
      report_mismatch($sformatf("%0d match words never arrived", expected_match.size()));
    $display("Ran %0d text words and %0d match words over %0d pattern settings,",
             n_words, n_results, n_settings);
    $display("with input gaps, output stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/wgm_pkg.sv
rtl/core/wgm_cfg.sv
rtl/core/wgm_nfa.sv
rtl/core/wildcard_glob_matcher.sv
tb/tb_wildcard_glob_matcher.sv
